/* src/lpr_pkg.sv */
// Package for the line pixel rasterizer: request codes, line flag struct,
// default coordinate width and color width. No dependencies.
`default_nettype none

package lpr_pkg;

  localparam int unsigned CoordBitsDef = 12;
  localparam int unsigned ColorBits    = 8;

  typedef enum logic {
    REQ_LOAD = 1'b0,
    REQ_TICK = 1'b1
  } req_type_e;

  // Orientation of the active line.
  typedef struct packed {
    logic y_is_major;
    logic minor_descends;
  } line_flags_t;

endpackage : lpr_pkg

`default_nettype wire

/* src/line_pixel_rasterizer_core.sv */
// Line pixel rasterizer top level: input register, line state, output register.
// A tick beat passes through the input register and then the output register before it leaves as a pixel beat.
// Throughput: one beat per cycle while the master side accepts, set by the combinational step (one add/compare).
// Loads and idle ticks emit nothing.
// Reset (rst_ni low, async): channels empty, line idle, line state zero.
`default_nettype none

module line_pixel_rasterizer_core #(
  parameter int unsigned COORD_BITS = lpr_pkg::CoordBitsDef
) (
  input  logic clk_i,
  input  logic rst_ni,

  // slave side
  input  logic                     s_axis_tvalid_i,
  output logic                     s_axis_tready_o,
  // x_start, y_start, x_end, y_end, red_in, green_in, blue_in (low to high)
  input  logic [((4*COORD_BITS+3*lpr_pkg::ColorBits+7)/8)*8-1:0] s_axis_tdata_i,
  // req_type
  input  logic                     s_axis_tuser_i,

  // master side
  output logic                     m_axis_tvalid_o,
  input  logic                     m_axis_tready_i,
  // pixel_x, pixel_y, red_out, green_out, blue_out (low to high)
  output logic [((2*COORD_BITS+3*lpr_pkg::ColorBits+7)/8)*8-1:0] m_axis_tdata_o,
  // last_pixel
  output logic                     m_axis_tlast_o
);
  import lpr_pkg::*;

  localparam int unsigned CB      = COORD_BITS;
  localparam int unsigned ColW    = 3 * ColorBits;
  localparam int unsigned InW     = ((4*CB + ColW + 7) / 8) * 8;
  localparam int unsigned OutW    = ((2*CB + ColW + 7) / 8) * 8;
  localparam int unsigned OutUsed = 2*CB + ColW;

  // ---------------------------------------------------------------------
  // Input register: holds one beat until the line stage can take it.
  // ---------------------------------------------------------------------
  logic           in_valid_q, in_valid_d;
  logic           in_type_q,  in_type_d;
  logic [InW-1:0] in_data_q,  in_data_d;

  logic advance;  // line stage may consume the held beat
  logic take;     // held beat consumed this cycle
  logic out_valid_q, out_valid_d;

  assign advance         = !out_valid_q || m_axis_tready_i;
  assign take            = in_valid_q && advance;
  assign s_axis_tready_o = !in_valid_q || advance;

  always_comb begin
    in_valid_d = in_valid_q;
    in_type_d  = in_type_q;
    in_data_d  = in_data_q;
    if (s_axis_tready_o) begin
      in_valid_d = s_axis_tvalid_i;
      in_type_d  = s_axis_tuser_i;
      in_data_d  = s_axis_tdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_type_q <= in_type_d;
    in_data_q <= in_data_d;
  end

  // unpack the held beat
  logic [CB-1:0]        xs, ys, xe, ye;
  logic [ColorBits-1:0] red_in, green_in, blue_in;

  assign xs       = in_data_q[0*CB +: CB];
  assign ys       = in_data_q[1*CB +: CB];
  assign xe       = in_data_q[2*CB +: CB];
  assign ye       = in_data_q[3*CB +: CB];
  assign red_in   = in_data_q[4*CB + 0*ColorBits +: ColorBits];
  assign green_in = in_data_q[4*CB + 1*ColorBits +: ColorBits];
  assign blue_in  = in_data_q[4*CB + 2*ColorBits +: ColorBits];

  // ---------------------------------------------------------------------
  // Line state
  // ---------------------------------------------------------------------
  logic          active_q, active_d;
  logic [CB-1:0] cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  logic [CB:0]   err_q, err_d;
  logic [CB-1:0] major_q, major_d, minor_q, minor_d;
  logic [CB-1:0] left_q, left_d;   // pixels still to come after the current one
  line_flags_t   flags_q, flags_d;
  logic [ColW-1:0] colour_q, colour_d;

  // setup of a new line from the held beat
  logic [CB-1:0] ld_major, ld_minor, ld_x, ld_y;
  line_flags_t   ld_flags;

  lpr_setup #(.COORD_BITS(CB)) u_setup (
    .x_start_i     (xs),
    .y_start_i     (ys),
    .x_end_i       (xe),
    .y_end_i       (ye),
    .major_delta_o (ld_major),
    .minor_delta_o (ld_minor),
    .cur_x_o       (ld_x),
    .cur_y_o       (ld_y),
    .flags_o       (ld_flags)
  );

  // next pixel position of the active line
  logic [CB-1:0] st_x, st_y;
  logic [CB:0]   st_err;

  lpr_step #(.COORD_BITS(CB)) u_step (
    .cur_x_i       (cur_x_q),
    .cur_y_i       (cur_y_q),
    .step_error_i  (err_q),
    .major_delta_i (major_q),
    .minor_delta_i (minor_q),
    .flags_i       (flags_q),
    .nxt_x_o       (st_x),
    .nxt_y_o       (st_y),
    .nxt_error_o   (st_err)
  );

  logic is_load, emit, last;

  assign is_load = take && (req_type_e'(in_type_q) == REQ_LOAD);
  assign emit    = take && (req_type_e'(in_type_q) == REQ_TICK) && active_q;
  assign last    = (left_q == '0);

  always_comb begin
    active_d = active_q;
    cur_x_d  = cur_x_q;
    cur_y_d  = cur_y_q;
    err_d    = err_q;
    major_d  = major_q;
    minor_d  = minor_q;
    left_d   = left_q;
    flags_d  = flags_q;
    colour_d = colour_q;
    if (is_load) begin
      // a load drops any line in progress
      active_d = 1'b1;
      cur_x_d  = ld_x;
      cur_y_d  = ld_y;
      err_d    = '0;
      major_d  = ld_major;
      minor_d  = ld_minor;
      left_d   = ld_major;
      flags_d  = ld_flags;
      colour_d = {red_in, green_in, blue_in};
    end else if (emit) begin
      if (last) begin
        active_d = 1'b0;
      end else begin
        cur_x_d = st_x;
        cur_y_d = st_y;
        err_d   = st_err;
        left_d  = left_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      cur_x_q  <= '0;
      cur_y_q  <= '0;
      err_q    <= '0;
      major_q  <= '0;
      minor_q  <= '0;
      left_q   <= '0;
      flags_q  <= '0;
      colour_q <= '0;
    end else begin
      active_q <= active_d;
      cur_x_q  <= cur_x_d;
      cur_y_q  <= cur_y_d;
      err_q    <= err_d;
      major_q  <= major_d;
      minor_q  <= minor_d;
      left_q   <= left_d;
      flags_q  <= flags_d;
      colour_q <= colour_d;
    end
  end

  // ---------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------
  logic [OutUsed-1:0] out_data_q, out_data_d;
  logic               out_last_q, out_last_d;

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    out_last_d  = out_last_q;
    if (advance) begin
      out_valid_d = emit;
      out_data_d  = {colour_q[0 +: ColorBits], colour_q[ColorBits +: ColorBits],
                     colour_q[2*ColorBits +: ColorBits], cur_y_q, cur_x_q};
      out_last_d  = last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    out_last_q <= out_last_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = OutW'(out_data_q);
  assign m_axis_tlast_o  = out_last_q;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_load_activates : assert property (@(posedge clk_i) disable iff (!rst_ni)
    is_load |=> active_q)
    else $error("line not active after load");

  a_last_ends_line : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && last) |=> !active_q)
    else $error("line still active after last pixel");

  a_err_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> ((err_q < {1'b0, major_q}) || (err_q == '0)))
    else $error("error term out of range");

  a_out_from_tick : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(emit))
    else $error("pixel beat without an active tick");

  a_hold_input : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !advance) |=> (in_valid_q && $stable(in_data_q)))
    else $error("held input beat lost");

endmodule : line_pixel_rasterizer_core

`default_nettype wire

/* src/lpr_setup.sv */
// Line setup: deltas, major axis, start point and minor direction from two
// endpoints. Pure combinational logic. Depends on lpr_pkg.
`default_nettype none

module lpr_setup #(
  parameter int unsigned COORD_BITS = lpr_pkg::CoordBitsDef
) (
  input  logic [COORD_BITS-1:0] x_start_i,
  input  logic [COORD_BITS-1:0] y_start_i,
  input  logic [COORD_BITS-1:0] x_end_i,
  input  logic [COORD_BITS-1:0] y_end_i,
  output logic [COORD_BITS-1:0] major_delta_o,
  output logic [COORD_BITS-1:0] minor_delta_o,
  output logic [COORD_BITS-1:0] cur_x_o,
  output logic [COORD_BITS-1:0] cur_y_o,
  output lpr_pkg::line_flags_t  flags_o
);
  import lpr_pkg::*;

  logic [COORD_BITS-1:0] adx, ady;
  logic [COORD_BITS-1:0] ma0, mi0, ma1, mi1;
  logic [COORD_BITS-1:0] mi_first;
  logic                  y_major, swap;

  always_comb begin
    adx = (x_end_i >= x_start_i) ? (x_end_i - x_start_i) : (x_start_i - x_end_i);
    ady = (y_end_i >= y_start_i) ? (y_end_i - y_start_i) : (y_start_i - y_end_i);
    y_major = (adx < ady);

    if (y_major) begin
      ma0 = y_start_i; mi0 = x_start_i; ma1 = y_end_i; mi1 = x_end_i;
      major_delta_o = ady;
      minor_delta_o = adx;
    end else begin
      ma0 = x_start_i; mi0 = y_start_i; ma1 = x_end_i; mi1 = y_end_i;
      major_delta_o = adx;
      minor_delta_o = ady;
    end

    // walk from the endpoint with the smaller major coordinate
    swap = (ma1 < ma0);
    mi_first = swap ? mi1 : mi0;
    flags_o.y_is_major     = y_major;
    flags_o.minor_descends = swap ? (mi0 < mi1) : (mi1 < mi0);

    if (y_major) begin
      cur_y_o = swap ? ma1 : ma0;
      cur_x_o = mi_first;
    end else begin
      cur_x_o = swap ? ma1 : ma0;
      cur_y_o = mi_first;
    end
  end

endmodule : lpr_setup

`default_nettype wire

/* src/lpr_step.sv */
// One Bresenham step: major coordinate +1, error update, conditional minor
// step. Pure combinational logic. Depends on lpr_pkg.
`default_nettype none

module lpr_step #(
  parameter int unsigned COORD_BITS = lpr_pkg::CoordBitsDef
) (
  input  logic [COORD_BITS-1:0] cur_x_i,
  input  logic [COORD_BITS-1:0] cur_y_i,
  input  logic [COORD_BITS:0]   step_error_i,
  input  logic [COORD_BITS-1:0] major_delta_i,
  input  logic [COORD_BITS-1:0] minor_delta_i,
  input  lpr_pkg::line_flags_t  flags_i,
  output logic [COORD_BITS-1:0] nxt_x_o,
  output logic [COORD_BITS-1:0] nxt_y_o,
  output logic [COORD_BITS:0]   nxt_error_o
);
  import lpr_pkg::*;

  logic [COORD_BITS-1:0] maj, mnr, maj_nxt, mnr_nxt;
  logic [COORD_BITS:0]   err_sum;
  logic                  minor_step;

  always_comb begin
    maj = flags_i.y_is_major ? cur_y_i : cur_x_i;
    mnr = flags_i.y_is_major ? cur_x_i : cur_y_i;
    maj_nxt = maj + 1'b1;

    err_sum    = step_error_i + {1'b0, minor_delta_i};
    minor_step = (err_sum >= {1'b0, major_delta_i});
    if (minor_step) begin
      nxt_error_o = err_sum - {1'b0, major_delta_i};
      mnr_nxt     = flags_i.minor_descends ? (mnr - 1'b1) : (mnr + 1'b1);
    end else begin
      nxt_error_o = err_sum;
      mnr_nxt     = mnr;
    end

    nxt_x_o = flags_i.y_is_major ? mnr_nxt : maj_nxt;
    nxt_y_o = flags_i.y_is_major ? maj_nxt : mnr_nxt;
  end

endmodule : lpr_step

`default_nettype wire

/* dv/testbench.sv */
// Self-checking bench for line_pixel_rasterizer_core: directed and random line
// loads and ticks, a scoreboard class that steps its own copy of the line state.
// Depends on lpr_pkg and line_pixel_rasterizer_core.
`default_nettype none

module testbench;
  import lpr_pkg::*;

  localparam int unsigned CB       = CoordBitsDef;
  localparam int unsigned SW       = ((4*CB + 3*ColorBits + 7) / 8) * 8;
  localparam int unsigned MW       = ((2*CB + 3*ColorBits + 7) / 8) * 8;
  localparam int unsigned MaxCoord = (1 << CB) - 1;
  localparam int unsigned NumItems = 1300;
  localparam int unsigned HoldLen  = 400;
  localparam int unsigned Limit    = 200000;

  typedef struct packed {
    logic [CB-1:0]        x;
    logic [CB-1:0]        y;
    logic [ColorBits-1:0] red;
    logic [ColorBits-1:0] green;
    logic [ColorBits-1:0] blue;
    logic                 last;
  } pixel_t;

  // Tracks the line walk and holds the pixels still owed by the block.
  class raster_scoreboard;
    logic                   active;
    logic [CB-1:0]          cur_x, cur_y, major_d, minor_d, left;
    logic [CB:0]            err;
    line_flags_t            flags;
    logic [3*ColorBits-1:0] colour;  // red in the low byte
    pixel_t                 pixel_q[$];
    int unsigned            errors;

    function new();
      active  = 1'b0;
      cur_x   = '0;
      cur_y   = '0;
      major_d = '0;
      minor_d = '0;
      left    = '0;
      err     = '0;
      flags   = '0;
      colour  = '0;
      errors  = 0;
    endfunction

    function void note_request(req_type_e req, logic [SW-1:0] d);
      pixel_t        px;
      logic [CB-1:0] xs, ys, xe, ye, adx, ady, ma0, mi0, ma1, mi1, t;
      if (req == REQ_LOAD) begin
        xs  = d[0    +: CB];
        ys  = d[CB   +: CB];
        xe  = d[2*CB +: CB];
        ye  = d[3*CB +: CB];
        adx = (xe >= xs) ? xe - xs : xs - xe;
        ady = (ye >= ys) ? ye - ys : ys - ye;
        flags.y_is_major = (adx < ady);
        if (flags.y_is_major) begin
          ma0 = ys; mi0 = xs; ma1 = ye; mi1 = xe;
          major_d = ady; minor_d = adx;
        end else begin
          ma0 = xs; mi0 = ys; ma1 = xe; mi1 = ye;
          major_d = adx; minor_d = ady;
        end
        // walk always starts at the smaller major coordinate
        if (ma1 < ma0) begin
          t = ma0; ma0 = ma1; ma1 = t;
          t = mi0; mi0 = mi1; mi1 = t;
        end
        flags.minor_descends = (mi1 < mi0);
        if (flags.y_is_major) begin
          cur_y = ma0; cur_x = mi0;
        end else begin
          cur_x = ma0; cur_y = mi0;
        end
        err    = '0;
        left   = major_d;
        colour = d[4*CB +: 3*ColorBits];
        active = 1'b1;
      end else if (active) begin
        px.x     = cur_x;
        px.y     = cur_y;
        px.red   = colour[0           +: ColorBits];
        px.green = colour[ColorBits   +: ColorBits];
        px.blue  = colour[2*ColorBits +: ColorBits];
        px.last  = (left == '0);
        pixel_q.push_back(px);
        if (px.last) begin
          active = 1'b0;
        end else begin
          left = left - 1'b1;
          if (flags.y_is_major) cur_y = cur_y + 1'b1;
          else                  cur_x = cur_x + 1'b1;
          err = err + {1'b0, minor_d};
          if (err >= {1'b0, major_d}) begin
            if (flags.y_is_major)
              cur_x = flags.minor_descends ? cur_x - 1'b1 : cur_x + 1'b1;
            else
              cur_y = flags.minor_descends ? cur_y - 1'b1 : cur_y + 1'b1;
            err = err - {1'b0, major_d};
          end
        end
      end
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        errors++;
        $error("%s: expected %0d, got %0d", name, want, got);
      end
    endfunction

    function void check_pixel(logic [MW-1:0] d, logic last);
      pixel_t want;
      if (pixel_q.size() == 0) begin
        errors++;
        $error("pixel beat with nothing pending: data %h", d);
        return;
      end
      want = pixel_q.pop_front();
      compare_field("pixel_x",    32'(want.x),     32'(d[0    +: CB]));
      compare_field("pixel_y",    32'(want.y),     32'(d[CB   +: CB]));
      compare_field("red_out",    32'(want.red),   32'(d[2*CB +: ColorBits]));
      compare_field("green_out",  32'(want.green), 32'(d[2*CB+ColorBits   +: ColorBits]));
      compare_field("blue_out",   32'(want.blue),  32'(d[2*CB+2*ColorBits +: ColorBits]));
      compare_field("last_pixel", 32'(want.last),  32'(last));
    endfunction

    function int unsigned pending();
      return pixel_q.size();
    endfunction
  endclass

  logic          clk     = 1'b0;
  logic          rst_n   = 1'b0;
  logic          s_valid = 1'b0;
  logic [SW-1:0] s_data  = '0;
  logic          s_user  = 1'b0;
  logic          m_ready = 1'b0;
  logic          s_ready;
  logic          m_valid;
  logic [MW-1:0] m_data;
  logic          m_last;

  bit            steady   = 1'b0;  // no idling on either side while set
  bit            hold_req = 1'b0;  // asks the receiver for one long hold-off
  int unsigned   hold_left = 0;
  int unsigned   n_items   = 0;
  int unsigned   cycles    = 0;

  raster_scoreboard sb = new();

  line_pixel_rasterizer_core u_top (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tlast_o  (m_last)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Beats are taken at the edge, before any NBA of that step lands.
  always @(posedge clk) begin
    if (rst_n && s_valid && s_ready) sb.note_request(req_type_e'(s_user), s_data);
    if (rst_n && m_valid && m_ready) sb.check_pixel(m_data, m_last);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > Limit) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Pixel sink: random back-pressure plus one long hold-off on request.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HoldLen;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_ready <= 1'b0;
      end else begin
        m_ready <= steady || ($urandom_range(99) >= 35);
      end
    end
  end

  function automatic logic [SW-1:0] pack_line(logic [CB-1:0] xs, logic [CB-1:0] ys,
                                              logic [CB-1:0] xe, logic [CB-1:0] ye,
                                              logic [7:0] r, logic [7:0] g, logic [7:0] b);
    logic [SW-1:0] d;
    d = '0;
    d[0 +: 4*CB+3*ColorBits] = {b, g, r, ye, xe, ys, xs};
    return d;
  endfunction

  function automatic logic [SW-1:0] rand_payload();
    return pack_line(CB'($urandom_range(MaxCoord)), CB'($urandom_range(MaxCoord)),
                     CB'($urandom_range(MaxCoord)), CB'($urandom_range(MaxCoord)),
                     8'($urandom_range(255)), 8'($urandom_range(255)),
                     8'($urandom_range(255)));
  endfunction

  // Coordinate within span of c, kept inside the coordinate range.
  function automatic logic [CB-1:0] near(logic [CB-1:0] c, int unsigned span);
    int unsigned d;
    d = $urandom_range(span, 0);
    if ($urandom_range(1, 0) == 1) return (c + d <= MaxCoord) ? CB'(c + d) : CB'(c - d);
    return (c >= d) ? CB'(c - d) : CB'(c + d);
  endfunction

  // Offer one beat, with random idle cycles first unless steady; returns after acceptance.
  task automatic send_item(input req_type_e req, input logic [SW-1:0] payload);
    if (!steady) begin
      while ($urandom_range(99) < 35) begin
        s_valid <= 1'b0;
        @(posedge clk);
      end
    end
    s_valid <= 1'b1;
    s_data  <= payload;
    s_user  <= req;
    do @(posedge clk); while (!s_ready);
    n_items++;
  endtask

  task automatic send_ticks(input int unsigned n);
    repeat (n) send_item(REQ_TICK, rand_payload());
  endtask

  // Load a random line of at most span per axis, then tick it out: usually the
  // whole line, sometimes cut short by the next load, sometimes idle ticks after.
  task automatic draw_line(input int unsigned span, input int unsigned tick_cap);
    logic [CB-1:0] xs, ys, xe, ye, adx, ady;
    int unsigned   n, major, roll;
    xs  = CB'($urandom_range(MaxCoord));
    ys  = CB'($urandom_range(MaxCoord));
    xe  = near(xs, span);
    ye  = near(ys, span);
    adx = (xe >= xs) ? xe - xs : xs - xe;
    ady = (ye >= ys) ? ye - ys : ys - ye;
    major = (adx >= ady) ? 32'(adx) : 32'(ady);
    send_item(REQ_LOAD, pack_line(xs, ys, xe, ye, 8'($urandom_range(255)),
                                  8'($urandom_range(255)), 8'($urandom_range(255))));
    n    = major + 1;
    roll = $urandom_range(99);
    if (roll < 12)      n = $urandom_range(major, 0);
    else if (roll < 22) n = n + $urandom_range(3, 1);
    if (n > tick_cap) n = tick_cap;
    send_ticks(n);
  endtask

  initial begin
    int unsigned roll;
    bit          pressure_done;
    pressure_done = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // tick with no line loaded
    send_item(REQ_TICK, rand_payload());
    // single point, black
    send_item(REQ_LOAD, pack_line(0, 0, 0, 0, 8'h00, 8'h00, 8'h00));
    send_ticks(2);
    // full-range diagonal, white, reversed endpoints; aborted after three pixels
    send_item(REQ_LOAD, pack_line(CB'(MaxCoord), CB'(MaxCoord), 0, 0,
                                  8'hff, 8'hff, 8'hff));
    send_ticks(3);
    // x major, endpoints swapped, minor axis descending
    send_item(REQ_LOAD, pack_line(6, 0, 0, 3, 8'h12, 8'h34, 8'h56));
    send_ticks(7);
    // y major at the top of the range, endpoints swapped
    send_item(REQ_LOAD, pack_line(0, CB'(MaxCoord), 1, CB'(MaxCoord - 6),
                                  8'ha5, 8'h5a, 8'hc3));
    send_ticks(8);

    while (n_items < NumItems) begin
      steady = (n_items >= 800 && n_items < 1000);
      if (!pressure_done && n_items >= 400) begin
        // sink stalls while a long line keeps ticking: the block must back up
        pressure_done = 1'b1;
        hold_req = 1'b1;
        send_item(REQ_LOAD, pack_line(100, 200, 260, 150, 8'h0f, 8'hf0, 8'h3c));
        send_ticks(161);
      end
      roll = $urandom_range(99);
      if (roll < 8)       send_item(REQ_TICK, rand_payload());
      else if (roll < 14) draw_line(MaxCoord, 8);
      else if (roll < 19) draw_line(300, 400);
      else                draw_line(24, 64);
    end
    steady = 1'b0;

    // one line spanning the whole x range, cut short after its first pixels
    send_item(REQ_LOAD, pack_line(0, CB'($urandom_range(MaxCoord)), CB'(MaxCoord),
                                  CB'($urandom_range(MaxCoord)), 8'($urandom_range(255)),
                                  8'($urandom_range(255)), 8'($urandom_range(255))));
    send_ticks(32);
    s_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
